FILE: rtl/ktap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ktap_pkg
// Shared types and codes for the key tap, double-tap and auto-repeat classifier.
// -----------------------------------------------------------------------------
package ktap_pkg;

   localparam int CFG_BITS  = 16;
   localparam int EV_BITS   = 2;
   localparam int TIME_IN_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   // Event codes carried in key_event.
   localparam logic [EV_BITS-1:0] EV_NONE   = 2'd0;
   localparam logic [EV_BITS-1:0] EV_SINGLE = 2'd1;
   localparam logic [EV_BITS-1:0] EV_DOUBLE = 2'd2;
   localparam logic [EV_BITS-1:0] EV_REPEAT = 2'd3;

   // Register indexes (word address on the configuration port).
   localparam logic [1:0] REG_DOUBLE_TAP_WINDOW = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS_DELAY  = 2'd1;
   localparam logic [1:0] REG_REPEAT_INTERVAL   = 2'd2;

   localparam logic [CFG_BITS-1:0] DOUBLE_TAP_WINDOW_RST = 16'd300;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_DELAY_RST  = 16'd300;
   localparam logic [CFG_BITS-1:0] REPEAT_INTERVAL_RST   = 16'd50;

   typedef struct packed {
      logic [CFG_BITS-1:0] double_tap_window;
      logic [CFG_BITS-1:0] long_press_delay;
      logic [CFG_BITS-1:0] repeat_interval;
   } ktap_cfg_type;

endpackage
`default_nettype wire

FILE: rtl/ktap_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ktap_classify
// Combinational classification of one key sample against the timing state.
// -----------------------------------------------------------------------------
module ktap_classify
   import ktap_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire ktap_cfg_type         cfg,
   input  wire logic                 press_edge,
   input  wire logic                 key_held,
   input  wire logic [TIME_BITS-1:0] time_now,
   input  wire logic [TIME_BITS-1:0] last_press_time,
   input  wire logic [TIME_BITS-1:0] last_event_time,
   input  wire logic                 awaiting_long_press,
   output logic [TIME_BITS-1:0]      last_press_time_next,
   output logic [TIME_BITS-1:0]      last_event_time_next,
   output logic                      awaiting_long_press_next,
   output logic [EV_BITS-1:0]        key_event
);

   logic [TIME_BITS-1:0] since_press;
   logic [TIME_BITS-1:0] since_event;
   logic [TIME_BITS-1:0] window_ext;
   logic [TIME_BITS-1:0] delay_ext;
   logic [TIME_BITS-1:0] interval_ext;

   // Differences wrap naturally at the state width.
   assign since_press  = time_now - last_press_time;
   assign since_event  = time_now - last_event_time;
   assign window_ext   = TIME_BITS'(cfg.double_tap_window);
   assign delay_ext    = TIME_BITS'(cfg.long_press_delay);
   assign interval_ext = TIME_BITS'(cfg.repeat_interval);

   always_comb begin
      last_press_time_next     = last_press_time;
      last_event_time_next     = last_event_time;
      awaiting_long_press_next = awaiting_long_press;
      key_event                = EV_NONE;
      // A press edge always wins over the held level.
      priority if (press_edge) begin
         last_event_time_next     = time_now;
         awaiting_long_press_next = 1'b1;
         if (since_press < window_ext) begin
            last_press_time_next = '0;
            key_event            = EV_DOUBLE;
         end else begin
            last_press_time_next = time_now;
            key_event            = EV_SINGLE;
         end
      end else if (key_held) begin
         if (awaiting_long_press) begin
            if (since_event > delay_ext) begin
               last_event_time_next     = time_now;
               awaiting_long_press_next = 1'b0;
               key_event                = EV_REPEAT;
            end
         end else if (since_event > interval_ext) begin
            last_event_time_next = time_now;
            key_event            = EV_REPEAT;
         end
      end else begin
         key_event = EV_NONE;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/key_tap_double_tap_repeat.sv
// An accepted req item passes the input register, then the result register, to
// become its rsp item. Throughput: one item per cycle unless rsp_tready stalls the output;
// every item gives one result; the timing state is updated at the same edge the result is registered.
// Reset: synchronous, active high; clears the valid flags, the timing state and
// loads the register defaults (300 ms window, 300 ms delay, 50 ms interval).
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// key_tap_double_tap_repeat
// Single-key tap, double-tap and auto-repeat classifier with stream ports.
// -----------------------------------------------------------------------------
module key_tap_double_tap_repeat
   import ktap_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [0] press_edge, [1] key_held, [33:2] time_now, [39:34] zero
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [1:0] key_event, [7:2] zero
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   ktap_cfg_type cfg_ff, cfg_in;

   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_edge_ff, stage_edge_in;
   logic                 stage_held_ff, stage_held_in;
   logic [TIME_BITS-1:0] stage_time_ff, stage_time_in;

   logic [TIME_BITS-1:0] last_press_time_ff, last_press_time_in;
   logic [TIME_BITS-1:0] last_event_time_ff, last_event_time_in;
   logic                 awaiting_ff, awaiting_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [EV_BITS-1:0]   rsp_event_ff, rsp_event_in;

   logic [TIME_BITS-1:0] press_next;
   logic [TIME_BITS-1:0] event_next;
   logic                 awaiting_next;
   logic [EV_BITS-1:0]   event_code;
   logic [TIME_BITS+TIME_IN_BITS-1:0] time_wide;
   logic                 rsp_load;
   logic                 csr_write;
   logic [1:0]           csr_index;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DOUBLE_TAP_WINDOW: cfg_in.double_tap_window = csr_pwdata[CFG_BITS-1:0];
            REG_LONG_PRESS_DELAY:  cfg_in.long_press_delay  = csr_pwdata[CFG_BITS-1:0];
            REG_REPEAT_INTERVAL:   cfg_in.repeat_interval   = csr_pwdata[CFG_BITS-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DOUBLE_TAP_WINDOW: csr_prdata = CSR_DATA_BITS'(cfg_ff.double_tap_window);
         REG_LONG_PRESS_DELAY:  csr_prdata = CSR_DATA_BITS'(cfg_ff.long_press_delay);
         REG_REPEAT_INTERVAL:   csr_prdata = CSR_DATA_BITS'(cfg_ff.repeat_interval);
         default:               csr_prdata = '0;
      endcase
   end

   // The result register loads when the input register holds an item and it is empty or being drained.
   assign rsp_load   = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || rsp_load;

   // Only the low TIME_BITS bits of the timestamp matter; wider states zero-extend.
   assign time_wide = {{TIME_BITS{1'b0}}, req_tdata[33:2]};

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_edge_in  = stage_edge_ff;
      stage_held_in  = stage_held_ff;
      stage_time_in  = stage_time_ff;
      if (req_tready) begin
         stage_valid_in = req_tvalid;
         stage_edge_in  = req_tdata[0];
         stage_held_in  = req_tdata[1];
         stage_time_in  = time_wide[TIME_BITS-1:0];
      end
   end

   ktap_classify #(
      .TIME_BITS (TIME_BITS)
   ) u_classify (
      .cfg                      (cfg_ff),
      .press_edge               (stage_edge_ff),
      .key_held                 (stage_held_ff),
      .time_now                 (stage_time_ff),
      .last_press_time          (last_press_time_ff),
      .last_event_time          (last_event_time_ff),
      .awaiting_long_press      (awaiting_ff),
      .last_press_time_next     (press_next),
      .last_event_time_next     (event_next),
      .awaiting_long_press_next (awaiting_next),
      .key_event                (event_code)
   );

   always_comb begin
      last_press_time_in = last_press_time_ff;
      last_event_time_in = last_event_time_ff;
      awaiting_in        = awaiting_ff;
      rsp_event_in       = rsp_event_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         last_press_time_in = press_next;
         last_event_time_in = event_next;
         awaiting_in        = awaiting_next;
         rsp_event_in       = event_code;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_tap_window <= DOUBLE_TAP_WINDOW_RST;
         cfg_ff.long_press_delay  <= LONG_PRESS_DELAY_RST;
         cfg_ff.repeat_interval   <= REPEAT_INTERVAL_RST;
         stage_valid_ff           <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         last_press_time_ff       <= '0;
         last_event_time_ff       <= '0;
         awaiting_ff              <= 1'b0;
      end else begin
         cfg_ff             <= cfg_in;
         stage_valid_ff     <= stage_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         last_press_time_ff <= last_press_time_in;
         last_event_time_ff <= last_event_time_in;
         awaiting_ff        <= awaiting_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_edge_ff <= stage_edge_in;
      stage_held_ff <= stage_held_in;
      stage_time_ff <= stage_time_in;
      rsp_event_ff  <= rsp_event_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-EV_BITS){1'b0}}, rsp_event_ff};

`ifndef SYNTHESIS
   // The long-press wait is only armed by a tap.
   a_arm_by_tap: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !awaiting_ff && awaiting_next) |-> stage_edge_ff)
      else $error("long-press wait armed without a press edge");

   // A sample with a press edge never yields a repeat.
   a_no_repeat_on_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && stage_edge_ff) |-> (event_code == EV_SINGLE || event_code == EV_DOUBLE))
      else $error("press edge not classified as a tap");

   // A double tap clears the recorded press time.
   a_double_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && event_code == EV_DOUBLE) |=> (last_press_time_ff == '0))
      else $error("press time not cleared after double tap");
`endif

endmodule
`default_nettype wire
